[hdl/jse_pkg.sv]
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, character codes and helpers of the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

	// Character codes that the escaper emits or recognizes.
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_N = 8'h6e;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_DEL = 8'h7f;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Raw control bytes with a two-character escape.
	localparam logic [7:0] RAW_BS = 8'h08;
	localparam logic [7:0] RAW_TAB = 8'h09;
	localparam logic [7:0] RAW_LF = 8'h0a;
	localparam logic [7:0] RAW_FF = 8'h0c;
	localparam logic [7:0] RAW_CR = 8'h0d;

	// UTF-8 lead byte ranges.
	localparam logic [7:0] LEAD2_LO = 8'hc2;
	localparam logic [7:0] LEAD2_HI = 8'hdf;
	localparam logic [7:0] LEAD3_LO = 8'he0;
	localparam logic [7:0] LEAD3_HI = 8'hef;
	localparam logic [7:0] LEAD4_LO = 8'hf0;
	localparam logic [7:0] LEAD4_HI = 8'hf4;

	// Code point limits.
	localparam logic [20:0] CP_MIN3 = 21'h000800;
	localparam logic [20:0] CP_MIN4 = 21'h010000;
	localparam logic [20:0] CP_SUR_LO = 21'h00d800;
	localparam logic [20:0] CP_SUR_HI = 21'h00dfff;
	localparam logic [20:0] CP_MAX = 21'h10ffff;

	// Kind of the body segment of a run.
	localparam logic [1:0] BODY_NONE = 2'd0;
	localparam logic [1:0] BODY_LIT = 2'd1;
	localparam logic [1:0] BODY_PAIR = 2'd2;
	localparam logic [1:0] BODY_UESC = 2'd3;

	// One accepted input word.
	typedef struct packed {
		logic [7:0] data_byte;
		logic has_byte;
		logic first_of_string;
		logic last_of_string;
	} item_t;

	// Description of the output run of one item, in emission order:
	// opening quote, leading replacements, body, trailing replacements,
	// closing quote.
	typedef struct packed {
		logic open_q;
		logic [2:0] rep_a;
		logic [1:0] body_kind;
		logic [2:0] lit_len;
		logic [3:0][7:0] lit;
		logic [1:0] rep_b;
		logic close_q;
	} run_desc_t;

	function automatic logic [7:0] hex_lower(input logic [3:0] v);
		hex_lower = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h61 + {4'd0, v} - 8'd10);
	endfunction

	// Byte at a position of the six-byte replacement escape.
	function automatic logic [7:0] repl_byte(input logic [2:0] pos);
		case (pos)
			3'd0: repl_byte = CH_BSLASH;
			3'd1: repl_byte = CH_U;
			3'd2, 3'd3, 3'd4: repl_byte = CH_F;
			default: repl_byte = CH_D;
		endcase
	endfunction

endpackage

[hdl/jse_in_if.sv]
// ----------------------------------------------------------------------------
// jse_in_if
// Input channel of the escaper: one string byte and its framing marks.
// ----------------------------------------------------------------------------
interface jse_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic has_byte;
	logic first_of_string;
	logic last_of_string;

	modport source (output valid, output data_byte, output has_byte,
		output first_of_string, output last_of_string, input ready);
	modport sink (input valid, input data_byte, input has_byte,
		input first_of_string, input last_of_string, output ready);
endinterface

[hdl/jse_out_if.sv]
// ----------------------------------------------------------------------------
// jse_out_if
// Output channel of the escaper: one byte of escaped JSON text.
// ----------------------------------------------------------------------------
interface jse_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

[hdl/json_string_escaper_utf8_unit.sv]
// ----------------------------------------------------------------------------
// json_string_escaper_utf8_unit
// Streams a string, one byte per input word, out as quoted JSON text with
// UTF-8 validation. An input word is taken every cycle as long as each word
// yields at most one output byte and the output is not stalled; a word that
// yields N bytes (N up to 25, for example a six-byte escape or a run of
// replacement escapes) holds the byte-wide output register until all N bytes
// are out, so the rate is set by the output sequencer. A word that yields
// nothing (no byte and no marks, or a byte that only extends a pending UTF-8
// sequence) is taken without waiting on the output and passes no output. The
// first output byte of a word passes from the input register through the run
// register into the output register, where it can be taken when the output
// is not stalled. Quotes, backslashes and control bytes are escaped;
// well-formed multi-byte UTF-8 passes through unchanged once complete, and
// any malformed byte is replaced by the escape of U+FFFD. The output word
// flagged last_of_run closes the output of one input word.
// ----------------------------------------------------------------------------
module json_string_escaper_utf8_unit import jse_pkg::*; (
	input logic clk,
	input logic arst_n,
	jse_in_if.sink item,
	jse_out_if.source result
);

	// The input register holds one word while its run description is built.
	logic v_s1;
	item_t item_s1;

	logic item_take;
	logic desc_valid;
	logic desc_ready;
	run_desc_t desc;

	// A new word is taken whenever the held one moves on in the same cycle.
	assign item.ready = !v_s1 || item_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.data_byte <= item.data_byte;
			item_s1.has_byte <= item.has_byte;
			item_s1.first_of_string <= item.first_of_string;
			item_s1.last_of_string <= item.last_of_string;
		end
	end

	// Decide the output run of the held word and advance the UTF-8 state.
	jse_classify u_classify (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_s1),
		.item_valid(v_s1),
		.desc_ready(desc_ready),
		.item_take(item_take),
		.desc_valid(desc_valid),
		.desc(desc)
	);

	// Play the run out one byte per cycle through the output register while the output is not stalled.
	jse_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.desc_valid(desc_valid),
		.desc(desc),
		.desc_ready(desc_ready),
		.result(result)
	);

endmodule

[hdl/jse_classify.sv]
// ----------------------------------------------------------------------------
// jse_classify
// UTF-8 tracking state and the decision logic that turns one item into a
// run description.
// ----------------------------------------------------------------------------
module jse_classify import jse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input item_t item,
	input logic item_valid,
	input logic desc_ready,
	output logic item_take,
	output logic desc_valid,
	output run_desc_t desc
);

	logic [2:0][7:0] pend_q;
	logic [1:0] pc_q;
	logic [2:0] sl_q;

	logic [2:0][7:0] n_pend;
	logic [1:0] n_pc;
	logic [2:0] n_sl;
	logic [1:0] pc_e;
	logic [2:0] sl_e;
	logic do_fresh;
	logic seq_ok;
	logic [20:0] cp;
	logic [7:0] b;
	logic empty;

	// Fresh byte decode.
	logic [1:0] f_kind;
	logic [7:0] f_char;
	logic f_lead;
	logic [2:0] f_sl;
	logic f_stray;

	assign b = item.data_byte;

	always_comb begin
		f_kind = BODY_NONE;
		f_char = b;
		f_lead = 1'b0;
		f_sl = 3'd0;
		f_stray = 1'b0;
		unique case (b)
			CH_QUOTE: begin f_kind = BODY_PAIR; f_char = CH_QUOTE; end
			CH_BSLASH: begin f_kind = BODY_PAIR; f_char = CH_BSLASH; end
			RAW_BS: begin f_kind = BODY_PAIR; f_char = CH_B; end
			RAW_FF: begin f_kind = BODY_PAIR; f_char = CH_F; end
			RAW_LF: begin f_kind = BODY_PAIR; f_char = CH_N; end
			RAW_CR: begin f_kind = BODY_PAIR; f_char = CH_R; end
			RAW_TAB: begin f_kind = BODY_PAIR; f_char = CH_T; end
			default: begin
				if (b < CH_SPACE || b == CH_DEL) begin
					f_kind = BODY_UESC;
				end else if (!b[7]) begin
					f_kind = BODY_LIT;
				end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
					f_lead = 1'b1;
					f_sl = 3'd2;
				end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
					f_lead = 1'b1;
					f_sl = 3'd3;
				end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
					f_lead = 1'b1;
					f_sl = 3'd4;
				end else begin
					f_stray = 1'b1;
				end
			end
		endcase
	end

	// Check of the code point that a final continuation byte completes.
	always_comb begin
		cp = '0;
		seq_ok = 1'b1;
		case (sl_e)
			3'd3: begin
				cp = {5'd0, pend_q[0][3:0], pend_q[1][5:0], b[5:0]};
				seq_ok = !(cp < CP_MIN3 || (cp >= CP_SUR_LO && cp <= CP_SUR_HI));
			end
			3'd4: begin
				cp = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0], b[5:0]};
				seq_ok = !(cp < CP_MIN4 || cp > CP_MAX);
			end
			default: seq_ok = 1'b1;
		endcase
	end

	always_comb begin
		pc_e = item.first_of_string ? 2'd0 : pc_q;
		sl_e = item.first_of_string ? 3'd0 : sl_q;
		n_pend = pend_q;
		n_pc = pc_e;
		n_sl = sl_e;
		do_fresh = 1'b0;
		desc = '0;
		desc.open_q = item.first_of_string;
		if (item.has_byte) begin
			if (pc_e == 2'd0) begin
				do_fresh = 1'b1;
			end else if (b[7:6] != 2'b10) begin
				// Broken sequence: replace what is held, then start over.
				desc.rep_a = {1'b0, pc_e};
				n_pc = 2'd0;
				n_sl = 3'd0;
				do_fresh = 1'b1;
			end else if (({1'b0, pc_e} + 3'd1) >= sl_e) begin
				n_pc = 2'd0;
				n_sl = 3'd0;
				if (seq_ok) begin
					desc.body_kind = BODY_LIT;
					desc.lit_len = {1'b0, pc_e} + 3'd1;
					desc.lit[0] = pend_q[0];
					desc.lit[1] = pend_q[1];
					desc.lit[2] = pend_q[2];
					desc.lit[pc_e] = b;
				end else begin
					desc.rep_a = {1'b0, pc_e} + 3'd1;
				end
			end else begin
				n_pend[pc_e] = b;
				n_pc = pc_e + 2'd1;
			end
		end
		if (do_fresh) begin
			desc.body_kind = f_kind;
			desc.lit_len = 3'd1;
			desc.lit[0] = f_char;
			desc.rep_a = desc.rep_a + {2'd0, f_stray};
			if (f_lead) begin
				n_pend[0] = b;
				n_pc = 2'd1;
				n_sl = f_sl;
			end
		end
		if (item.last_of_string) begin
			desc.rep_b = n_pc;
			desc.close_q = 1'b1;
			n_pc = 2'd0;
			n_sl = 3'd0;
		end
	end

	assign empty = !desc.open_q && desc.rep_a == 3'd0 && desc.body_kind == BODY_NONE
		&& desc.rep_b == 2'd0 && !desc.close_q;
	assign item_take = item_valid && (empty || desc_ready);
	assign desc_valid = item_valid && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 2'd0;
			sl_q <= 3'd0;
			pend_q <= '0;
		end else if (item_take) begin
			pc_q <= n_pc;
			sl_q <= n_sl;
			pend_q <= n_pend;
		end
	end

endmodule

[hdl/jse_emit.sv]
// ----------------------------------------------------------------------------
// jse_emit
// Run register and byte sequencer that walks a run description and feeds
// the output register one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module jse_emit import jse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic desc_valid,
	input run_desc_t desc,
	output logic desc_ready,
	jse_out_if.source result
);

	localparam logic [2:0] PH_OPEN = 3'd0;
	localparam logic [2:0] PH_REPA = 3'd1;
	localparam logic [2:0] PH_BODY = 3'd2;
	localparam logic [2:0] PH_REPB = 3'd3;
	localparam logic [2:0] PH_CLOSE = 3'd4;
	localparam logic [2:0] PH_DONE = 3'd5;

	logic dv_q;
	run_desc_t desc_q;
	logic [2:0] ph_q;
	logic [2:0] pos_q;
	logic [2:0] cnt_q;
	logic ov_q;
	logic [7:0] ob_q;
	logic ol_q;

	logic out_free;
	logic step;
	logic [2:0] len;
	logic seg_end;
	logic more_reps;
	logic [2:0] nxt;
	logic is_last;
	logic [7:0] cur_byte;
	logic load;
	logic [2:0] load_ph;

	function automatic logic [4:0] seg_present(input run_desc_t d);
		seg_present = {d.close_q, d.rep_b != 2'd0, d.body_kind != BODY_NONE,
			d.rep_a != 3'd0, d.open_q};
	endfunction

	// Lowest segment at or after start that has something to emit.
	function automatic logic [2:0] first_from(input logic [4:0] ne, input logic [2:0] start);
		logic [2:0] r;
		r = PH_DONE;
		for (int i = 4; i >= 0; i--) begin
			if (3'(i) >= start && ne[i]) begin
				r = 3'(i);
			end
		end
		first_from = r;
	endfunction

	function automatic logic [2:0] seg_count(input logic [2:0] ph, input run_desc_t d);
		case (ph)
			PH_REPA: seg_count = d.rep_a;
			PH_REPB: seg_count = {1'b0, d.rep_b};
			default: seg_count = 3'd1;
		endcase
	endfunction

	assign out_free = !ov_q || result.ready;
	assign step = dv_q && out_free;

	always_comb begin
		case (ph_q)
			PH_REPA, PH_REPB: len = 3'd6;
			PH_BODY: begin
				case (desc_q.body_kind)
					BODY_LIT: len = desc_q.lit_len;
					BODY_PAIR: len = 3'd2;
					default: len = 3'd6;
				endcase
			end
			default: len = 3'd1;
		endcase
	end

	assign seg_end = pos_q == (len - 3'd1);
	assign more_reps = cnt_q > 3'd1;
	assign nxt = first_from(seg_present(desc_q), ph_q + 3'd1);
	assign is_last = seg_end && !more_reps && nxt == PH_DONE;

	always_comb begin
		case (ph_q)
			PH_REPA, PH_REPB: cur_byte = repl_byte(pos_q);
			PH_BODY: begin
				case (desc_q.body_kind)
					BODY_LIT: cur_byte = desc_q.lit[pos_q[1:0]];
					BODY_PAIR: cur_byte = (pos_q == 3'd0) ? CH_BSLASH : desc_q.lit[0];
					default: begin
						case (pos_q)
							3'd0: cur_byte = CH_BSLASH;
							3'd1: cur_byte = CH_U;
							3'd2, 3'd3: cur_byte = CH_ZERO;
							3'd4: cur_byte = hex_lower(desc_q.lit[0][7:4]);
							default: cur_byte = hex_lower(desc_q.lit[0][3:0]);
						endcase
					end
				endcase
			end
			default: cur_byte = CH_QUOTE;
		endcase
	end

	assign desc_ready = !dv_q || (step && is_last);
	assign load = desc_ready && desc_valid;
	assign load_ph = first_from(seg_present(desc), PH_OPEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q <= 1'b0;
			ph_q <= PH_OPEN;
			pos_q <= 3'd0;
			cnt_q <= 3'd0;
			ov_q <= 1'b0;
		end else begin
			if (step) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
			if (desc_ready) begin
				dv_q <= desc_valid;
				if (desc_valid) begin
					ph_q <= load_ph;
					pos_q <= 3'd0;
					cnt_q <= seg_count(load_ph, desc);
				end
			end else if (step) begin
				if (!seg_end) begin
					pos_q <= pos_q + 3'd1;
				end else if (more_reps) begin
					pos_q <= 3'd0;
					cnt_q <= cnt_q - 3'd1;
				end else begin
					pos_q <= 3'd0;
					ph_q <= nxt;
					cnt_q <= seg_count(nxt, desc_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			desc_q <= desc;
		end
		if (step) begin
			ob_q <= cur_byte;
			ol_q <= is_last;
		end
	end

	assign result.valid = ov_q;
	assign result.out_byte = ob_q;
	assign result.last_of_run = ol_q;

endmodule
